### design/pig_pkg.sv
// shared types, constants and row functions of the prime implicant generator
package pig_pkg;

	// number of input variables of the function (1 to 4)
	localparam int VARIABLES = 4;
	localparam int MASK_W    = VARIABLES;
	localparam int ROWS      = 1 << VARIABLES;
	localparam int FIELD_W   = 4;
	localparam int K_W       = (VARIABLES > 1) ? $clog2(VARIABLES) : 1;

	typedef struct packed {
		logic [FIELD_W-1:0] minterm;
		logic               last;
	} item_t;

	typedef struct packed {
		logic [FIELD_W-1:0] implicant_value;
		logic [FIELD_W-1:0] dont_care_mask;
		logic               final_res;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_RD,
		ST_WR,
		ST_ERD,
		ST_ELD,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	// one row of the cube store holds the present bits of all values of one mask
	typedef struct packed {
		logic              rd_en;
		logic [MASK_W-1:0] rd_addr;
		logic              wr_en;
		logic [MASK_W-1:0] wr_addr;
		logic [ROWS-1:0]   wr_data;
	} ram_req_t;

	// cubes formed by joining pairs of a row across variable k, at value with bit k clear
	function automatic logic [ROWS-1:0] pair_row(input logic [ROWS-1:0] row,
		input logic [K_W-1:0] k);
		logic [ROWS-1:0] res;
		res = '0;
		for (int v = 0; v < ROWS; v++) begin
			for (int kk = 0; kk < VARIABLES; kk++) begin
				if ((K_W'(kk) == k) && (((v >> kk) & 1) == 0)) begin
					res[v] = row[v] & row[MASK_W'(v | (1 << kk))];
				end
			end
		end
		return res;
	endfunction

	// present cubes of a row that have no partner across any free variable
	function automatic logic [ROWS-1:0] prime_row(input logic [ROWS-1:0] row,
		input logic [MASK_W-1:0] mask);
		logic [ROWS-1:0] comb;
		comb = '0;
		for (int v = 0; v < ROWS; v++) begin
			for (int kk = 0; kk < VARIABLES; kk++) begin
				if (!mask[kk]) begin
					comb[v] = comb[v] | (row[v] & row[MASK_W'(v ^ (1 << kk))]);
				end
			end
		end
		return row & ~comb;
	endfunction

	// index of the lowest set bit
	function automatic logic [MASK_W-1:0] lowest_bit(input logic [ROWS-1:0] vec);
		logic [MASK_W-1:0] idx;
		idx = '0;
		for (int v = ROWS - 1; v >= 0; v--) begin
			if (vec[v]) begin
				idx = MASK_W'(v);
			end
		end
		return idx;
	endfunction

endpackage

### design/pig_row_ram.sv
// cube store: one row per mask, registered read
module pig_row_ram (
	input  logic                          clk,
	input  pig_pkg::ram_req_t             req,
	output logic [pig_pkg::ROWS-1:0]      rd_data
);

	logic [pig_pkg::ROWS-1:0] mem [pig_pkg::ROWS];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

### design/prime_implicant_generator.sv
// top level: quine-mccluskey prime implicant generator
//
// minterms arrive one transaction each on item (start high while busy is low) and
// are merged into a registered bitmap, so a set loads at one minterm per clock;
// duplicates change nothing. the transaction with last set loads its minterm and then
// starts the reduction, during which busy stays high. the cube store is one memory
// of one row per mask (a bit per value) with a single read port, and the reduction
// builds each row from the rows one variable below it: one read per variable plus a
// write. emission then reads each row once, takes out its prime implicants one by
// one and ends in a closing flush state. results come in ascending order of mask,
// then value, each shown for exactly one cycle with result_valid high; the receiver
// cannot stall them, so it must take every strobe. final_res marks the last
// implicant of the set. the final result may appear in the first cycle after busy
// falls; every row is rewritten by the next reduction, so the store needs no
// clearing pass.
module prime_implicant_generator (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  pig_pkg::item_t   item,
	output logic             result_valid,
	output pig_pkg::result_t result
);

	localparam logic [pig_pkg::K_W-1:0]    KLAST = pig_pkg::K_W'(pig_pkg::VARIABLES - 1);
	localparam logic [pig_pkg::MASK_W-1:0] MLAST = pig_pkg::MASK_W'(pig_pkg::ROWS - 1);

	pig_pkg::state_t   state_q, state_nxt;
	pig_pkg::ram_req_t ram_req;
	pig_pkg::result_t  result_q;

	logic [pig_pkg::ROWS-1:0]   bitmap_q;     // loaded minterms
	logic [pig_pkg::ROWS-1:0]   acc_q;        // row under construction
	logic [pig_pkg::ROWS-1:0]   acc_nxt;
	logic [pig_pkg::ROWS-1:0]   prime_q;      // primes of the row being emitted
	logic [pig_pkg::ROWS-1:0]   rd_data;
	logic [pig_pkg::MASK_W-1:0] m_q;          // current mask (row)
	logic [pig_pkg::K_W-1:0]    k_q;          // variable index of the next read
	logic [pig_pkg::K_W-1:0]    k_s1;         // variable index of the returning read
	logic                       rd_valid_s1;
	logic [pig_pkg::MASK_W-1:0] low_v;
	logic [pig_pkg::MASK_W-1:0] pend_v_q, pend_m_q;
	logic                       pend_valid_q;
	logic                       res_valid_q;
	logic                       found;

	pig_row_ram u_ram (
		.clk     (clk),
		.req     (ram_req),
		.rd_data (rd_data)
	);

	// fold in the row one variable below, only when that variable is eliminated in m
	assign acc_nxt = acc_q | ((rd_valid_s1 && m_q[k_s1]) ?
		pig_pkg::pair_row(rd_data, k_s1) : '0);

	assign low_v = pig_pkg::lowest_bit(prime_q);
	assign found = (state_q == pig_pkg::ST_SCAN) && (prime_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pig_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt       = state_q;
		busy            = 1'b1;
		ram_req         = '0;
		case (state_q)
			pig_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start && item.last) begin
					state_nxt = pig_pkg::ST_INIT;
				end
			end
			pig_pkg::ST_INIT: begin
				// row of mask zero is the minterm set itself
				ram_req.wr_en   = 1'b1;
				ram_req.wr_addr = '0;
				ram_req.wr_data = bitmap_q;
				state_nxt       = pig_pkg::ST_RD;
			end
			pig_pkg::ST_RD: begin
				ram_req.rd_en   = 1'b1;
				ram_req.rd_addr = m_q ^ (pig_pkg::MASK_W'(1) << k_q);
				if (k_q == KLAST) begin
					state_nxt = pig_pkg::ST_WR;
				end
			end
			pig_pkg::ST_WR: begin
				ram_req.wr_en   = 1'b1;
				ram_req.wr_addr = m_q;
				ram_req.wr_data = acc_nxt;
				state_nxt       = (m_q == MLAST) ? pig_pkg::ST_ERD : pig_pkg::ST_RD;
			end
			pig_pkg::ST_ERD: begin
				ram_req.rd_en   = 1'b1;
				ram_req.rd_addr = m_q;
				state_nxt       = pig_pkg::ST_ELD;
			end
			pig_pkg::ST_ELD: begin
				state_nxt = pig_pkg::ST_SCAN;
			end
			pig_pkg::ST_SCAN: begin
				if (prime_q == '0) begin
					state_nxt = (m_q == MLAST) ? pig_pkg::ST_FLUSH : pig_pkg::ST_ERD;
				end
			end
			pig_pkg::ST_FLUSH: begin
				state_nxt = pig_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = pig_pkg::ST_IDLE;
			end
		endcase
	end

	// sequencing counters and the reduction accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q         <= '0;
			k_q         <= '0;
			k_s1        <= '0;
			rd_valid_s1 <= 1'b0;
			acc_q       <= '0;
			bitmap_q    <= '0;
		end else begin
			rd_valid_s1 <= (state_q == pig_pkg::ST_RD);
			k_s1        <= k_q;
			case (state_q)
				pig_pkg::ST_IDLE: begin
					if (start) begin
						bitmap_q <= bitmap_q |
							(pig_pkg::ROWS'(1) << item.minterm[pig_pkg::MASK_W-1:0]);
					end
				end
				pig_pkg::ST_INIT: begin
					m_q   <= pig_pkg::MASK_W'(1);
					k_q   <= '0;
					acc_q <= '0;
				end
				pig_pkg::ST_RD: begin
					k_q   <= k_q + 1'b1;
					acc_q <= acc_nxt;
				end
				pig_pkg::ST_WR: begin
					// wraps to mask zero for the emission sweep
					m_q   <= m_q + 1'b1;
					k_q   <= '0;
					acc_q <= '0;
				end
				pig_pkg::ST_SCAN: begin
					if (prime_q == '0) begin
						m_q <= m_q + 1'b1;
					end
				end
				pig_pkg::ST_FLUSH: begin
					bitmap_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pig_pkg::ST_ELD) begin
			prime_q <= pig_pkg::prime_row(rd_data, m_q);
		end else if (found) begin
			prime_q <= prime_q & ~(pig_pkg::ROWS'(1) << low_v);
		end
	end

	// one-deep holding slot: an implicant leaves only once the next one, or the end, is known
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			res_valid_q <= (found && pend_valid_q) || (state_q == pig_pkg::ST_FLUSH);
			if (found) begin
				pend_valid_q <= 1'b1;
			end else if (state_q == pig_pkg::ST_FLUSH) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (found) begin
			pend_v_q <= low_v;
			pend_m_q <= m_q;
		end
		if (found || (state_q == pig_pkg::ST_FLUSH)) begin
			result_q.implicant_value <= pig_pkg::FIELD_W'(pend_v_q);
			result_q.dont_care_mask  <= pig_pkg::FIELD_W'(pend_m_q);
			result_q.final_res       <= (state_q == pig_pkg::ST_FLUSH);
		end
	end

	assign result_valid = res_valid_q;
	assign result       = result_q;

endmodule

### test/testbench.sv
// self-checking testbench for the prime implicant generator
`timescale 1ns / 1ps

module testbench;

	// no accepted transaction for this many cycles ends the run
	localparam int STALL_LIMIT = 4000;
	// cycles to idle after the last implicant, covers the closing cycle of a reduction
	localparam int DRAIN_CYCLES = 300;
	localparam int IDLE_PCT = 20;
	localparam int RANDOM_ITEMS = 85;

	// one queued minterm, optionally held back until all implicants have come out
	typedef struct {
		pig_pkg::item_t txn;
		bit             drain_first;
	} queued_minterm_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	pig_pkg::item_t   item = '0;
	logic             busy;
	logic             result_valid;
	pig_pkg::result_t result;

	queued_minterm_t  minterm_queue[$];
	pig_pkg::result_t pending_primes[$];

	logic [pig_pkg::ROWS-1:0] loaded_onset = '0;
	int              error_count = 0;
	int              minterms_sent = 0;
	int              sets_sent = 0;
	int              primes_checked = 0;
	int              stall_cycles = 0;

	// driver scratch
	logic            took;
	logic            want;
	queued_minterm_t next_txn;

	prime_implicant_generator uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result)
	);

	always #2 clk = ~clk;

	// tabular reduction of one on-set, appends the prime implicants in mask, value order
	function automatic void predict_primes(input logic [pig_pkg::ROWS-1:0] onset);
		logic [pig_pkg::ROWS-1:0] present [pig_pkg::ROWS];
		logic [pig_pkg::ROWS-1:0] joined [pig_pkg::ROWS];
		pig_pkg::result_t         found[$];
		pig_pkg::result_t         one;
		int                       partner;
		int                       bit_val;
		for (int m = 0; m < pig_pkg::ROWS; m++) begin
			present[m] = '0;
			joined[m] = '0;
		end
		present[0] = onset;
		// a cube of mask m only comes from masks numerically below m
		for (int m = 0; m < pig_pkg::ROWS; m++) begin
			for (int v = 0; v < pig_pkg::ROWS; v++) begin
				if ((v & m) != 0 || !present[m][v])
					continue;
				for (int b = 0; b < pig_pkg::VARIABLES; b++) begin
					bit_val = 1 << b;
					if ((m & bit_val) != 0)
						continue;
					partner = v ^ bit_val;
					if (!present[m][partner])
						continue;
					joined[m][v] = 1'b1;
					joined[m][partner] = 1'b1;
					present[m | bit_val][v & ~bit_val] = 1'b1;
				end
			end
		end
		for (int m = 0; m < pig_pkg::ROWS; m++) begin
			for (int v = 0; v < pig_pkg::ROWS; v++) begin
				if (present[m][v] && !joined[m][v]) begin
					one.implicant_value = pig_pkg::FIELD_W'(v);
					one.dont_care_mask = pig_pkg::FIELD_W'(m);
					one.final_res = 1'b0;
					found = {found, one};
				end
			end
		end
		if (found.size() > 0)
			found[found.size() - 1].final_res = 1'b1;
		foreach (found[i])
			pending_primes = {pending_primes, found[i]};
	endfunction

	task automatic queue_minterm(input int mt, input bit is_last, input bit drain);
		queued_minterm_t q;
		q.txn.minterm = pig_pkg::FIELD_W'(mt);
		q.txn.last = is_last;
		q.drain_first = drain;
		minterm_queue = {minterm_queue, q};
	endtask

	task automatic flag_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		error_count++;
	endtask

	// driver: start stays up until the transaction is taken, new ones at random except in a gap-free stretch
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			item <= '0;
		end else begin
			took = start && !busy;
			if (took) begin
				minterms_sent++;
				// bits at and above the variable count wrap into the function's range
				loaded_onset = loaded_onset |
					(pig_pkg::ROWS'(1) << (item.minterm & (pig_pkg::ROWS - 1)));
				if (item.last) begin
					predict_primes(loaded_onset);
					loaded_onset = '0;
					sets_sent++;
				end
			end
			if (took || !start) begin
				// a long stretch in the middle of the random part runs with no gaps
				want = minterm_queue.size() > 0 &&
					((minterms_sent >= 40 && minterms_sent < 75) ||
					$urandom_range(99) >= IDLE_PCT);
				if (want && minterm_queue[0].drain_first && pending_primes.size() != 0)
					want = 1'b0;
				if (want) begin
					next_txn = minterm_queue.pop_front();
					item <= next_txn.txn;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: every strobe is taken and compared against the oldest expected implicant
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (pending_primes.size() == 0) begin
				flag_mismatch($sformatf("unexpected implicant value %h mask %h",
					result.implicant_value, result.dont_care_mask));
			end else begin
				if (result.implicant_value !== pending_primes[0].implicant_value)
					flag_mismatch($sformatf("implicant_value %h, expected %h",
						result.implicant_value, pending_primes[0].implicant_value));
				if (result.dont_care_mask !== pending_primes[0].dont_care_mask)
					flag_mismatch($sformatf("dont_care_mask %h, expected %h",
						result.dont_care_mask, pending_primes[0].dont_care_mask));
				if (result.final_res !== pending_primes[0].final_res)
					flag_mismatch($sformatf("final_res %b, expected %b",
						result.final_res, pending_primes[0].final_res));
				void'(pending_primes.pop_front());
				primes_checked++;
			end
		end
	end

	// watchdog on cycles with no transaction either way
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || result_valid)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	initial begin
		int planned;
		int set_size;
		int set_no;
		int pause_set;

		// directed: single minterm at each end of the range
		queue_minterm(0, 1'b1, 1'b0);
		queue_minterm(15, 1'b1, 1'b0);
		// repeated minterm, the last one included
		queue_minterm(5, 1'b0, 1'b0);
		queue_minterm(5, 1'b0, 1'b0);
		queue_minterm(5, 1'b1, 1'b0);
		// every minterm true, held until the earlier sets have drained
		for (int i = 0; i < pig_pkg::ROWS; i++)
			queue_minterm(i, i == pig_pkg::ROWS - 1, i == 0);
		// two minterms with no common literal
		queue_minterm(6, 1'b0, 1'b0);
		queue_minterm(9, 1'b1, 1'b0);

		// random sets, mostly small, now and then a large one
		planned = 0;
		set_no = 0;
		pause_set = $urandom_range(12, 4);
		while (planned < RANDOM_ITEMS) begin
			set_size = ($urandom_range(8) == 0) ? $urandom_range(16, 10) : $urandom_range(8, 1);
			for (int i = 0; i < set_size; i++)
				queue_minterm($urandom_range(15), i == set_size - 1,
					i == 0 && set_no == pause_set);
			planned += set_size;
			set_no++;
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (minterm_queue.size() != 0 || start)
			@(posedge clk);
		while (pending_primes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("summary: %0d minterm transactions in %0d sets", minterms_sent, sets_sent);
		$display("summary: %0d prime implicants compared, %0d mismatches",
			primes_checked, error_count);
		if (error_count == 0 && pending_primes.size() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
